### rtl/mts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants of the min-tracking stack
// Word layouts of both channels, the stored entry type, the operation and
// status codes, and the control word that steers the row of stack cells.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int DATA_W     = 32;
  localparam int ENTRY_W    = DATA_W + 2;  // room for 2*x - min without overflow
  localparam int DEPTH_DEF  = 64;

  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;

  localparam data_t MIN_RESET   = 32'sh7FFF_FFFF;
  localparam data_t EMPTY_VALUE = -32'sd1;

  // operation codes; the unused code acts as a peek
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    data_t      push_value;
  } in_word_t;

  typedef struct packed {
    data_t      top_value;
    data_t      min_value;
    logic       is_empty;
    logic [1:0] status;
  } out_word_t;

  // per-cycle move of the cell row
  typedef struct packed {
    logic push;  // every cell takes the entry above it
    logic pop;   // every cell takes the entry below it
  } shift_t;

endpackage
`default_nettype wire

### rtl/mts_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_cell: one stack slot
// Holds one stored entry. On a push it takes its upper neighbor's entry, on
// a pop its lower neighbor's entry, otherwise it keeps its own.
// ----------------------------------------------------------------------------
module mts_cell (
  input  wire                clk,
  input  mts_pkg::shift_t    shift_i,
  input  mts_pkg::entry_t    above_i,
  input  mts_pkg::entry_t    below_i,
  output mts_pkg::entry_t    entry_o
);

  mts_pkg::entry_t entry_r;

  // slot register, payload only, no reset
  always_ff @(posedge clk) begin
    priority if (shift_i.push) begin
      entry_r <= above_i;
    end else if (shift_i.pop) begin
      entry_r <= below_i;
    end else begin
      entry_r <= entry_r;
    end
  end

  assign entry_o = entry_r;

endmodule
`default_nettype wire

### rtl/min_tracking_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack: bounded LIFO of signed 32-bit words with running minimum
// Each word is a push, pop or peek; each returns the decoded top, the minimum
// and the empty flag after the operation, plus a status code.
// ----------------------------------------------------------------------------
// One operation per clock: an input word is taken in any cycle in which the
// result register is empty or being drained, and its result appears in that
// register on the next cycle. Sustained rate, while the result side does not
// stall, is one word per cycle; the path that sets it is the top cell plus the
// minimum register, read, updated and stored at once. The stack is a row of
// STACK_DEPTH cells that shift together: cell 0 is always the top. A push
// below the minimum stores 2*x - min and makes x the minimum; popping such an
// entry restores the old minimum. An empty stack reports -1 for top and min.
// A push onto a full stack is dropped (status 1); a pop on an empty stack is
// ignored (status 2). No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
  parameter int STACK_DEPTH = mts_pkg::DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  mts_pkg::in_word_t     in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output mts_pkg::out_word_t    out_data
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  logic [CNT_W-1:0]    count_r, count_nxt;
  mts_pkg::data_t      min_r, min_nxt;
  logic                out_valid_r, out_valid_nxt;
  mts_pkg::out_word_t  out_data_r, out_data_nxt;

  mts_pkg::entry_t     cell_q [STACK_DEPTH];
  mts_pkg::entry_t     second_entry;
  mts_pkg::entry_t     new_entry;
  mts_pkg::shift_t     shift;
  logic                accept;

  // entry below the top, read when a pop uncovers it
  generate
    if (STACK_DEPTH > 1) begin : g_second
      assign second_entry = cell_q[1];
    end else begin : g_single
      assign second_entry = cell_q[0];
    end
  endgenerate

  // row of stack cells, top at index 0
  generate
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      mts_pkg::entry_t above, below;
      if (i == 0) begin : g_top
        assign above = new_entry;
      end else begin : g_mid
        assign above = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
        assign below = '0;
      end else begin : g_inner
        assign below = cell_q[i+1];
      end
      mts_cell u_cell (
        .clk     (clk),
        .shift_i (shift),
        .above_i (above),
        .below_i (below),
        .entry_o (cell_q[i])
      );
    end
  endgenerate

  // entry below the minimum is a flag and reads as the minimum
  function automatic mts_pkg::data_t decode(mts_pkg::entry_t t, mts_pkg::data_t mn);
    mts_pkg::entry_t mn_e;
    mn_e = mts_pkg::entry_t'(mn);
    return (t < mn_e) ? mn : t[mts_pkg::DATA_W-1:0];
  endfunction

  // handshake: the result register parts the two sides
  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  // operation decode and next state
  always_comb begin
    mts_pkg::entry_t x_e, min_e, top_e, restored;
    logic            empty, full;
    x_e      = mts_pkg::entry_t'(in_data.push_value);
    min_e    = mts_pkg::entry_t'(min_r);
    top_e    = cell_q[0];
    restored = (min_e <<< 1) - top_e;
    empty    = (count_r == '0);
    full     = (count_r == CNT_FULL);

    count_nxt  = count_r;
    min_nxt    = min_r;
    new_entry  = x_e;
    shift      = '0;
    out_data_nxt = out_data_r;
    out_data_nxt.status = mts_pkg::ST_OK;

    unique case (in_data.kind)
      mts_pkg::KIND_PUSH: begin
        if (full) begin
          out_data_nxt.status = mts_pkg::ST_FULL;
        end else begin
          shift.push = accept;
          count_nxt  = count_r + CNT_W'(1);
          if (empty || x_e >= min_e) begin
            new_entry = x_e;
          end else begin
            new_entry = (x_e <<< 1) - min_e;
          end
          if (empty || x_e < min_e) begin
            min_nxt = in_data.push_value;
          end
        end
      end
      mts_pkg::KIND_POP: begin
        if (empty) begin
          out_data_nxt.status = mts_pkg::ST_EMPTY;
        end else begin
          shift.pop = accept;
          count_nxt = count_r - CNT_W'(1);
          if (top_e < min_e) begin
            min_nxt = restored[mts_pkg::DATA_W-1:0];
          end
        end
      end
      default: begin
        // peek and the unused code leave the state alone
      end
    endcase

    // report the state after the operation
    out_data_nxt.is_empty = (count_nxt == '0);
    if (count_nxt == '0) begin
      out_data_nxt.top_value = mts_pkg::EMPTY_VALUE;
      out_data_nxt.min_value = mts_pkg::EMPTY_VALUE;
    end else begin
      out_data_nxt.min_value = min_nxt;
      if (shift.push) begin
        out_data_nxt.top_value = in_data.push_value;
      end else if (shift.pop) begin
        out_data_nxt.top_value = decode(second_entry, min_nxt);
      end else begin
        out_data_nxt.top_value = decode(top_e, min_r);
      end
    end

    out_valid_nxt = accept || (out_valid_r && out_stall);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      min_r       <= mts_pkg::MIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
        min_r   <= min_nxt;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // empty flag of the held result matches the entry count
  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_empty == (count_r == '0)))
    else $error("is_empty disagrees with entry count");

  // a dropped push only happens on a full stack
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == mts_pkg::ST_FULL) |-> (count_r == CNT_FULL))
    else $error("push dropped while stack not full");

  // an accepted push with room grows the stack by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.kind == mts_pkg::KIND_PUSH && count_r != CNT_FULL)
    |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not advance entry count");
`endif

endmodule
`default_nettype wire

### bench/mts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mts_checker: result predictor and comparator for the min-tracking stack
// Watches both channels. Every word taken on the input side is run through a
// private copy of the stack (34-bit entries, one minimum register). The
// result it should produce is queued. Every word leaving the result side is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module mts_checker #(
  parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  mts_pkg::in_word_t   in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  mts_pkg::out_word_t  out_data,
  output int                  fail_count,
  output int                  pending_results
);
  import mts_pkg::*;

  // shadow stack state
  entry_t    cells [DEPTH];
  int        used;
  entry_t    run_min;

  // results still owed by the block, oldest first
  out_word_t owed_words [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // one push/pop/peek on the shadow stack; returns the word the block should send
  function automatic out_word_t apply_stack_op(in_word_t w);
    entry_t    x;
    entry_t    t;
    out_word_t r;
    x        = {{2{w.push_value[DATA_W-1]}}, w.push_value};
    r        = '0;
    r.status = ST_OK;
    case (w.kind)
      KIND_PUSH: begin
        if (used >= DEPTH) begin
          r.status = ST_FULL;
        end else if (used == 0) begin
          cells[0] = x;
          run_min  = x;
          used     = 1;
        end else begin
          // a value below the minimum is stored as 2*x - min
          if (x >= run_min) begin
            cells[used] = x;
          end else begin
            cells[used] = 2 * x - run_min;
            run_min     = x;
          end
          used++;
        end
      end
      KIND_POP: begin
        if (used == 0) begin
          r.status = ST_EMPTY;
        end else begin
          used--;
          t = cells[used];
          // an entry below the minimum hides the previous minimum
          if (t < run_min) run_min = 2 * run_min - t;
        end
      end
      default: ;  // peek and the spare code change nothing
    endcase
    if (used == 0) begin
      r.top_value = EMPTY_VALUE;
      r.min_value = EMPTY_VALUE;
    end else begin
      t           = cells[used-1];
      r.top_value = (t < run_min) ? run_min[DATA_W-1:0] : t[DATA_W-1:0];
      r.min_value = run_min[DATA_W-1:0];
    end
    r.is_empty = (used == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      used    = 0;
      run_min = {{2{MIN_RESET[DATA_W-1]}}, MIN_RESET};
      owed_words.delete();
    end else begin
      // result side first: a word accepted now cannot answer this edge's input
      if (out_valid && !out_stall) begin
        if (owed_words.size() == 0) begin
          report_error($sformatf("unexpected result word %h", out_data));
        end else begin
          want = owed_words.pop_front();
          if (out_data.top_value !== want.top_value)
            report_error($sformatf("top_value got %h want %h",
                                   out_data.top_value, want.top_value));
          if (out_data.min_value !== want.min_value)
            report_error($sformatf("min_value got %h want %h",
                                   out_data.min_value, want.min_value));
          if (out_data.is_empty !== want.is_empty)
            report_error($sformatf("is_empty got %b want %b",
                                   out_data.is_empty, want.is_empty));
          if (out_data.status !== want.status)
            report_error($sformatf("status got %0d want %0d",
                                   out_data.status, want.status));
        end
      end
      if (in_valid && !in_stall) owed_words.push_back(apply_stack_op(in_data));
    end
    pending_results = owed_words.size();
  end

endmodule
`default_nettype wire

### bench/tb_min_tracking_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_min_tracking_stack: self-checking bench for the min-tracking stack
// A directed opening covers empty-stack pops and peeks, the spare operation
// code, extreme values and flag entries. Random bursts follow: fills to full
// and beyond, drains to empty and beyond, and mixed traffic. Both sides idle
// at random. mts_checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_min_tracking_stack;
  import mts_pkg::*;

  localparam int         DEPTH      = DEPTH_DEF;
  localparam int         RAND_WORDS = 500;
  localparam int         LIMIT_TU   = 400000;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum logic [1:0] {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  int        fail_count;
  int        pending_results;

  // stimulus bookkeeping: occupancy as the sender sees it
  int        stacked;
  int        sent;
  logic      calm;

  min_tracking_stack #(.STACK_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mts_checker #(.DEPTH(DEPTH)) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #LIMIT_TU;
    $display("Regression FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  function automatic in_word_t make_word(logic [1:0] k, data_t v);
    in_word_t w;
    w.kind       = k;
    w.push_value = v;
    return w;
  endfunction

  // mostly full-range values, with extremes and a narrow band that gives ties
  function automatic data_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return data_t'($urandom);
    if (r < 80) return data_t'($urandom_range(40)) - 32'sd20;
    if (r < 87) return 32'sh7FFF_FFFF;
    if (r < 94) return 32'sh8000_0000;
    return EMPTY_VALUE;
  endfunction

  function automatic in_word_t mixed_word();
    int r;
    r = $urandom_range(99);
    if (r < 45) return make_word(KIND_PUSH, pick_value());
    if (r < 80) return make_word(KIND_POP, data_t'($urandom));
    if (r < 95) return make_word(KIND_PEEK, data_t'($urandom));
    return make_word(KIND_SPARE, data_t'($urandom));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input in_word_t w);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.kind == KIND_PUSH && stacked < DEPTH) stacked++;
    else if (w.kind == KIND_POP && stacked > 0) stacked--;
    sent++;
    calm = (sent >= 150 && sent < 260);
    @(negedge clk);
  endtask

  initial begin
    in_word_t directed [$];
    burst_t   burst;
    int       r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    stacked  = 0;
    sent     = 0;
    calm     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opening
    directed = '{
      make_word(KIND_POP,   32'sh5A5A_A5A5),  // pop on empty
      make_word(KIND_PEEK,  32'sh0),          // peek on empty
      make_word(KIND_SPARE, 32'shFFFF_FFFF),  // spare code on empty
      make_word(KIND_PUSH,  32'sh7FFF_FFFF),  // first push, largest value
      make_word(KIND_PUSH,  32'sh8000_0000),  // deepest flag entry
      make_word(KIND_PEEK,  32'sh1234_5678),
      make_word(KIND_PUSH,  32'sh7FFF_FFFF),  // above the minimum
      make_word(KIND_PUSH,  32'sh8000_0000),  // equal to the minimum: plain
      make_word(KIND_POP,   32'sh0),
      make_word(KIND_POP,   32'sh0),
      make_word(KIND_POP,   32'sh0),          // flag pop restores the minimum
      make_word(KIND_POP,   32'sh0),          // back to empty
      make_word(KIND_POP,   32'sh0),
      make_word(KIND_PUSH,  -32'sd1),
      make_word(KIND_PUSH,  -32'sd5),
      make_word(KIND_PUSH,  -32'sd3),
      make_word(KIND_SPARE, 32'sh0),
      make_word(KIND_PUSH,  -32'sd5),
      make_word(KIND_PUSH,  32'sh8000_0000),
      make_word(KIND_POP,   32'sh0),
      make_word(KIND_POP,   32'sh0),
      make_word(KIND_POP,   32'sh0),
      make_word(KIND_POP,   32'sh0),
      make_word(KIND_POP,   32'sh0),
      make_word(KIND_POP,   32'sh0)
    };
    foreach (directed[i]) send_word(directed[i]);

    // random bursts
    while (sent < RAND_WORDS + directed.size()) begin
      r     = $urandom_range(3);
      burst = (r == 0) ? BURST_FILL : (r == 1) ? BURST_DRAIN : BURST_MIXED;
      case (burst)
        BURST_FILL: begin
          while (stacked < DEPTH) send_word(make_word(KIND_PUSH, pick_value()));
          repeat ($urandom_range(1, 4)) send_word(make_word(KIND_PUSH, pick_value()));
        end
        BURST_DRAIN: begin
          while (stacked > 0) begin
            if ($urandom_range(9) == 0) send_word(make_word(KIND_PEEK, data_t'($urandom)));
            else send_word(make_word(KIND_POP, data_t'($urandom)));
          end
          repeat ($urandom_range(1, 3)) send_word(make_word(KIND_POP, data_t'($urandom)));
        end
        default: begin
          repeat ($urandom_range(10, 40)) send_word(mixed_word());
        end
      endcase
    end
    in_valid <= 1'b0;

    // drain, then wait for any stray result word
    wait (pending_results == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
